@@ hdl/ffba_pkg.sv @@
// shared types and constants for the first-fit block allocator
`default_nettype none
package ffba_pkg;

   localparam logic [1:0] KIND_REBUILD = 2'd0;
   localparam logic [1:0] KIND_ALLOC   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_NOMEM    = 3'd2;
   localparam logic [2:0] ST_BADPTR   = 3'd3;
   localparam logic [2:0] ST_DBLFREE  = 3'd4;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_BYTES = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] req_size;
      logic [31:0] release_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] data_addr;
      logic [23:0] granted_size;
      logic [24:0] used_total;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/ffba_table.sv @@
// block table memory: one synchronous read port, one write port
`default_nettype none
module ffba_table
   import ffba_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int ENT_W = 55
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   output logic      [ENT_W-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [ENT_W-1:0] wr_data
);

   logic [ENT_W-1:0] mem [2**IDX_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_idx];
      end
   end

endmodule
`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
// top level: first-fit heap block allocator with a chained block table
// flow: rebuild, zero, unknown-kind and empty-chain requests go straight to done; allocate
//   or release walks the chain, reading then deciding on each block visited; a split first
//   searches the live bits for the lowest free slot, a release merge reads the next block
// throughput: one item at a time, set by the single table read port walking the chain
// reset: synchronous active high; chain empty, no spare slots, table contents undefined
`default_nettype none
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int OFFSET_WIDTH = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int OW = OFFSET_WIDTH;
   // entry: offset, size, used, link
   localparam int EW = OW + 24 + 1 + IW;
   localparam logic [CW-1:0] NBLK = CW'(MAX_BLOCKS);
   localparam logic [25:0]   HDR  = 26'(HEADER_BYTES);
   localparam logic [25:0]   CAP  = (OW >= 24) ? 26'h1000000 : 26'(1 << OW);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SLOT  = 4'd3;
   localparam logic [3:0] S_RDNX  = 4'd4;
   localparam logic [3:0] S_MERGE = 4'd5;
   localparam logic [3:0] S_SPLIT = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   typedef struct packed {
      logic [OW-1:0] offset;
      logic [23:0]   size;
      logic          used;
      logic [IW-1:0] link;
   } ent_type;

   logic [31:0]     heap_base_ff;
   logic [24:0]     heap_bytes_ff;
   logic [31:0]     base_latch_ff;
   logic [3:0]      state_ff, state_in;
   req_type         req_ff;
   logic [CW-1:0]   head_ff;
   logic [CW-1:0]   spare_ff;
   logic [24:0]     used_ff;
   logic [MAX_BLOCKS-1:0] live_ff;
   logic [IW-1:0]   cur_ff;
   logic [CW-1:0]   steps_ff;
   ent_type         cur_ent_ff;
   logic [IW-1:0]   slot_ff;
   logic [25:0]     need_ff;
   logic            out_valid_ff;
   rsp_type         out_ff;

   logic            rd_en, wr_en;
   logic [IW-1:0]   rd_idx, wr_idx;
   logic [EW-1:0]   rd_raw, wr_raw;
   ent_type         rd_ent, wr_ent;

   assign rd_ent = ent_type'(rd_raw);
   assign wr_raw = EW'(wr_ent);

   ffba_table #(.IDX_W(IW), .ENT_W(EW)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_raw),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_raw)
   );

   // configuration registers; the base is latched and the region size read only at rebuild
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_bytes_ff <= 25'd65536;
      end else if (csr_we) begin
         if (csr_index == CSR_HEAP_BASE) heap_base_ff <= csr_wdata;
         else heap_bytes_ff <= csr_wdata[24:0];
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // current block as read, and derived data pointer
   logic [31:0] cur_data;
   logic        cur_last;
   logic [25:0] region;
   logic [25:0] split_need;
   logic [25:0] merged;
   logic        slot_found;
   assign cur_data   = base_latch_ff + 32'(cur_ent_ff.offset) + 32'(HDR);
   assign cur_last   = (cur_ent_ff.link == cur_ff);
   assign region     = (26'(heap_bytes_ff) > CAP) ? CAP : 26'(heap_bytes_ff);
   assign split_need = need_ff + HDR + 26'd4;
   assign merged     = 26'(cur_ent_ff.size) + HDR + 26'(rd_ent.size);
   assign slot_found = !live_ff[slot_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NBLK;
         spare_ff     <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         base_latch_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff  <= req_data;
                  need_ff <= (26'(req_data.req_size) + 26'd3) & ~26'd3;
                  cur_ff  <= head_ff[IW-1:0];
                  steps_ff <= '0;
                  out_ff.data_addr    <= '0;
                  out_ff.granted_size <= '0;
                  if (req_data.kind == KIND_REBUILD) begin
                     base_latch_ff <= heap_base_ff;
                     used_ff  <= '0;
                     out_ff.status     <= ST_OK;
                     out_ff.used_total <= '0;
                     if (region < HDR) begin
                        live_ff  <= '0;
                        spare_ff <= NBLK;
                        head_ff  <= NBLK;
                     end else begin
                        live_ff  <= MAX_BLOCKS'(1);
                        spare_ff <= NBLK - 1'b1;
                        head_ff  <= '0;
                     end
                     state_ff <= S_DONE;
                  end else if (req_data.kind == KIND_ALLOC && req_data.req_size == '0) begin
                     out_ff.status <= ST_ZERO;
                     out_ff.used_total <= used_ff;
                     state_ff <= S_DONE;
                  end else if (req_data.kind == KIND_RELEASE && req_data.release_addr == '0) begin
                     out_ff.status <= ST_ZERO;
                     out_ff.used_total <= used_ff;
                     state_ff <= S_DONE;
                  end else if (req_data.kind == KIND_ALLOC || req_data.kind == KIND_RELEASE) begin
                     if (head_ff == NBLK) begin
                        out_ff.status <= (req_data.kind == KIND_ALLOC) ? ST_NOMEM : ST_BADPTR;
                        out_ff.used_total <= used_ff;
                        state_ff <= S_DONE;
                     end else begin
                        // head entry read issued on this transfer
                        out_ff.status <= ST_OK;
                        state_ff <= S_READ;
                     end
                  end else begin
                     out_ff.status <= ST_OK;
                     out_ff.used_total <= used_ff;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_READ: begin
               // read data arrives this cycle
               cur_ent_ff <= rd_ent;
               steps_ff   <= steps_ff + 1'b1;
               state_ff   <= S_CHECK;
            end
            S_CHECK: begin
               if (req_ff.kind == KIND_ALLOC) begin
                  if (!cur_ent_ff.used && 26'(cur_ent_ff.size) >= need_ff) begin
                     if (26'(cur_ent_ff.size) >= split_need && spare_ff != '0) begin
                        slot_ff  <= '0;
                        state_ff <= S_SLOT;
                     end else begin
                        used_ff <= used_ff + 25'(cur_ent_ff.size);
                        out_ff.used_total <= used_ff + 25'(cur_ent_ff.size);
                        out_ff.data_addr <= cur_data;
                        out_ff.granted_size <= cur_ent_ff.size;
                        state_ff <= S_DONE;
                     end
                  end else if (cur_last || steps_ff == NBLK) begin
                     out_ff.status <= ST_NOMEM;
                     out_ff.used_total <= used_ff;
                     state_ff <= S_DONE;
                  end else begin
                     // next entry read issued this cycle
                     cur_ff   <= cur_ent_ff.link;
                     state_ff <= S_READ;
                  end
               end else begin
                  if (cur_data == req_ff.release_addr) begin
                     if (!cur_ent_ff.used) begin
                        out_ff.status <= ST_DBLFREE;
                        out_ff.used_total <= used_ff;
                        state_ff <= S_DONE;
                     end else begin
                        out_ff.granted_size <= cur_ent_ff.size;
                        used_ff <= (used_ff >= 25'(cur_ent_ff.size)) ?
                                   used_ff - 25'(cur_ent_ff.size) : '0;
                        out_ff.used_total <= (used_ff >= 25'(cur_ent_ff.size)) ?
                                   used_ff - 25'(cur_ent_ff.size) : '0;
                        state_ff <= cur_last ? S_DONE : S_RDNX;
                     end
                  end else if (cur_last || steps_ff == NBLK) begin
                     out_ff.status <= ST_BADPTR;
                     out_ff.used_total <= used_ff;
                     state_ff <= S_DONE;
                  end else begin
                     cur_ff   <= cur_ent_ff.link;
                     state_ff <= S_READ;
                  end
               end
            end
            S_SLOT: begin
               // walk live bits for the lowest free slot
               if (slot_found) begin
                  live_ff[slot_ff] <= 1'b1;
                  spare_ff <= spare_ff - 1'b1;
                  state_ff <= S_SPLIT;
               end else begin
                  slot_ff <= slot_ff + 1'b1;
               end
            end
            S_SPLIT: begin
               used_ff <= used_ff + 25'(need_ff);
               out_ff.used_total <= used_ff + 25'(need_ff);
               out_ff.data_addr <= cur_data;
               out_ff.granted_size <= need_ff[23:0];
               state_ff <= S_DONE;
            end
            S_RDNX: begin
               // next block read issued in check, data here
               state_ff <= S_MERGE;
            end
            S_MERGE: begin
               if (!rd_ent.used) begin
                  live_ff[cur_ent_ff.link] <= 1'b0;
                  spare_ff <= spare_ff + 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // table port control
   always_comb begin
      rd_en  = 1'b0;
      rd_idx = cur_ff;
      wr_en  = 1'b0;
      wr_idx = cur_ff;
      wr_ent = cur_ent_ff;
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         // head entry, ready when the read state captures it
         rd_en  = 1'b1;
         rd_idx = head_ff[IW-1:0];
      end
      if (state_ff == S_CHECK) begin
         rd_en  = 1'b1;
         rd_idx = cur_ent_ff.link;
      end
      if (state_ff == S_IDLE && req_valid && req_ready &&
          req_data.kind == KIND_REBUILD && region >= HDR) begin
         wr_en  = 1'b1;
         wr_idx = '0;
         wr_ent.offset = '0;
         wr_ent.size   = 24'(region - HDR);
         wr_ent.used   = 1'b0;
         wr_ent.link   = '0;
      end
      if (state_ff == S_CHECK && req_ff.kind == KIND_ALLOC && !cur_ent_ff.used &&
          26'(cur_ent_ff.size) >= need_ff &&
          !(26'(cur_ent_ff.size) >= split_need && spare_ff != '0)) begin
         wr_en = 1'b1;
         wr_ent.used = 1'b1;
      end
      if (state_ff == S_CHECK && req_ff.kind == KIND_RELEASE &&
          cur_data == req_ff.release_addr && cur_ent_ff.used && cur_last) begin
         wr_en = 1'b1;
         wr_ent.used = 1'b0;
      end
      if (state_ff == S_SLOT && slot_found) begin
         // new free block after the taken part
         wr_en  = 1'b1;
         wr_idx = slot_ff;
         wr_ent.offset = OW'(32'(cur_ent_ff.offset) + 32'(HDR) + 32'(need_ff));
         wr_ent.size   = 24'(26'(cur_ent_ff.size) - need_ff - HDR);
         wr_ent.used   = 1'b0;
         wr_ent.link   = cur_last ? slot_ff : cur_ent_ff.link;
      end
      if (state_ff == S_SPLIT) begin
         wr_en = 1'b1;
         wr_ent.size = need_ff[23:0];
         wr_ent.used = 1'b1;
         wr_ent.link = slot_ff;
      end
      if (state_ff == S_MERGE) begin
         wr_en = 1'b1;
         wr_ent.used = 1'b0;
         if (!rd_ent.used) begin
            wr_ent.size = merged[23:0];
            wr_ent.link = (rd_ent.link == cur_ent_ff.link) ? cur_ff : rd_ent.link;
         end
      end
   end

   // spare count never exceeds the table depth
   a_spare_range: assert property (@(posedge clock) disable iff (reset)
      spare_ff <= NBLK) else $error("spare slot count out of range");

   // no new transfer while a result is still pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !req_ready) else $error("input taken with result pending");

   // a result appears only after the done state
   a_done_then_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_DONE) else $error("stray result");

   // the chain walk never runs past the table depth
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> steps_ff <= NBLK) else $error("chain walk overran");

endmodule
`default_nettype wire

@@ dv/tb_first_fit_block_allocator.sv @@
// testbench for the first-fit block allocator: random and directed heap traffic
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   localparam int SLOTS = 64;
   localparam int HDR = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
   localparam int HOLD_AFTER = 600;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   first_fit_block_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // heap model: block table, chain, latched base
   logic [31:0] cfg_base;
   logic [24:0] cfg_bytes;
   logic [23:0] blk_off [SLOTS];
   logic [23:0] blk_size [SLOTS];
   logic        blk_busy [SLOTS];
   int          blk_next [SLOTS];
   logic        slot_taken [SLOTS];
   int          head_slot;
   int          free_slots;
   logic [24:0] bytes_in_use;
   logic [31:0] base_held;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   logic [31:0] live_ptrs [$];     // data pointers handed out, used to build releases
   int n_fail = 0;
   int n_checked = 0;
   int n_sent = 0;

   function automatic logic [31:0] data_ptr(int i);
      return base_held + 32'(blk_off[i]) + 32'(HDR);
   endfunction

   function automatic rsp_type heap_step(req_type r);
      rsp_type o;
      int i, n, nx, s, region;
      logic [25:0] need;
      logic [23:0] freed;
      o = '0;
      case (r.kind)
         KIND_REBUILD: begin
            region = (cfg_bytes > 25'd16777216) ? 16777216 : int'(cfg_bytes);
            for (i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
            base_held = cfg_base;
            bytes_in_use = '0;
            free_slots = SLOTS;
            head_slot = SLOTS;
            if (region >= HDR) begin
               slot_taken[0] = 1'b1;
               free_slots = SLOTS - 1;
               blk_off[0] = '0;
               blk_size[0] = 24'(region - HDR);
               blk_busy[0] = 1'b0;
               blk_next[0] = 0;
               head_slot = 0;
            end
            o.status = ST_OK;
            o.used_total = '0;
            return o;
         end
         KIND_ALLOC: begin
            if (r.req_size == 0) begin
               o.status = ST_ZERO;
            end else begin
               need = (26'(r.req_size) + 26'd3) & ~26'd3;
               o.status = ST_NOMEM;
               i = head_slot;
               for (n = 0; n < SLOTS && i < SLOTS; n++) begin
                  nx = blk_next[i];
                  if (!blk_busy[i] && 26'(blk_size[i]) >= need) begin
                     if (26'(blk_size[i]) >= need + HDR + 4 && free_slots > 0) begin
                        s = 0;
                        while (slot_taken[s]) s++;
                        slot_taken[s] = 1'b1;
                        free_slots--;
                        blk_off[s] = 24'(26'(blk_off[i]) + HDR + need);
                        blk_size[s] = 24'(26'(blk_size[i]) - need - HDR);
                        blk_busy[s] = 1'b0;
                        blk_next[s] = (nx == i) ? s : nx;
                        blk_size[i] = 24'(need);
                        blk_next[i] = s;
                     end
                     blk_busy[i] = 1'b1;
                     bytes_in_use = bytes_in_use + 25'(blk_size[i]);
                     o.status = ST_OK;
                     o.data_addr = data_ptr(i);
                     o.granted_size = blk_size[i];
                     break;
                  end
                  if (nx == i) break;
                  i = nx;
               end
            end
         end
         KIND_RELEASE: begin
            if (r.release_addr == 0) begin
               o.status = ST_ZERO;
            end else begin
               o.status = ST_BADPTR;
               i = head_slot;
               for (n = 0; n < SLOTS && i < SLOTS; n++) begin
                  nx = blk_next[i];
                  if (data_ptr(i) == r.release_addr) begin
                     if (!blk_busy[i]) begin
                        o.status = ST_DBLFREE;
                     end else begin
                        freed = blk_size[i];
                        bytes_in_use = (bytes_in_use >= 25'(freed)) ?
                                       bytes_in_use - 25'(freed) : '0;
                        blk_busy[i] = 1'b0;
                        if (nx != i && !blk_busy[nx]) begin
                           blk_size[i] = blk_size[i] + 24'(HDR) + blk_size[nx];
                           blk_next[i] = (blk_next[nx] == nx) ? i : blk_next[nx];
                           slot_taken[nx] = 1'b0;
                           free_slots++;
                        end
                        o.status = ST_OK;
                        o.granted_size = freed;
                     end
                     break;
                  end
                  if (nx == i) break;
                  i = nx;
               end
            end
         end
         default: o.status = ST_OK;   // kind 3 does nothing
      endcase
      o.used_total = bytes_in_use;
      return o;
   endfunction

   // driver: random gaps, payload held until the transfer
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else begin
         if (req_valid) n_sent++;
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            tx_gap <= ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // prediction happens at transfer time in issue order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(heap_step(req_data));
      end
   end

   // monitor with its own random back-pressure and one long stall mid-run
   int rx_gap = 0;
   int rx_hold_left = 0;
   logic hold_started = 1'b0;
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transfer %p", $time, rsp_data);
            n_fail++;
         end else begin
            e = expected_rsps.pop_front();
            n_checked++;
            if (e.status !== rsp_data.status)
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
            if (e.data_addr !== rsp_data.data_addr)
               $display("%0t: data_addr exp %h got %h", $time, e.data_addr,
                        rsp_data.data_addr);
            if (e.granted_size !== rsp_data.granted_size)
               $display("%0t: granted_size exp %0d got %0d", $time, e.granted_size,
                        rsp_data.granted_size);
            if (e.used_total !== rsp_data.used_total)
               $display("%0t: used_total exp %0d got %0d", $time, e.used_total,
                        rsp_data.used_total);
            if (e !== rsp_data) n_fail++;
            // remember pointers for later releases
            if (e.status == ST_OK && e.data_addr != 0) live_ptrs.push_back(e.data_addr);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_started && n_checked >= HOLD_AFTER) begin
         // long stall while the sender keeps offering items
         hold_started <= 1'b1;
         rx_hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 4) == 0)
            rx_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
      end
   end

   // watchdog: cycles with no transfer on either side
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic req_type make_req(logic [1:0] k, logic [23:0] sz, logic [31:0] a);
      req_type r;
      r.kind = k;
      r.req_size = sz;
      r.release_addr = a;
      return r;
   endfunction

   task automatic push_req(req_type r);
      pending_reqs.push_back(r);
   endtask

   // wait until every queued item went out and all results came back
   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEAP_BASE) cfg_base = v;
      else cfg_bytes = v[24:0];
   endtask

   // mostly well-formed traffic: allocs mixed with releases of known pointers, plus some bad cases
   task automatic random_burst(int count, int max_size);
      int j, pick;
      logic [31:0] p;
      for (j = 0; j < count; j++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            push_req(make_req(KIND_ALLOC, ($urandom_range(0, 9) == 0) ?
                              24'($urandom) : 24'($urandom_range(1, max_size)), $urandom));
         end else if (pick < 85 && live_ptrs.size() > 0) begin
            p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
            push_req(make_req(KIND_RELEASE, 24'($urandom), p));
         end else if (pick < 92) begin
            push_req(make_req(KIND_RELEASE, 24'($urandom), $urandom));
         end else if (pick < 95) begin
            push_req(make_req(KIND_ALLOC, 24'd0, $urandom));
         end else if (pick < 97) begin
            push_req(make_req(2'd3, 24'($urandom), $urandom));
         end else begin
            push_req(make_req(KIND_REBUILD, 24'($urandom), $urandom));
            live_ptrs.delete();
         end
         while (pending_reqs.size() > 4) @(posedge clock);
      end
   endtask

   initial begin
      cfg_base = 32'd0;
      cfg_bytes = 25'd65536;
      head_slot = SLOTS;
      free_slots = 0;
      bytes_in_use = '0;
      base_held = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // before any rebuild: empty chain
      push_req(make_req(KIND_ALLOC, 24'd8, 32'd0));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'h10));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'd0));
      push_req(make_req(2'd3, 24'hFFFFFF, 32'hFFFFFFFF));
      wait_quiet();

      // small region, then directed corner cases at top-of-space base
      write_csr(CSR_HEAP_BASE, 32'hFFFFFFF0);
      write_csr(CSR_HEAP_BYTES, 32'd32);
      push_req(make_req(KIND_REBUILD, 24'd0, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'd1, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'd16, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'd0, 32'd0));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'h00000000));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'hFFFFFFF0 + 32'd16));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'hFFFFFFF0 + 32'd16));
      push_req(make_req(KIND_RELEASE, 24'd0, 32'h12345678));
      push_req(make_req(KIND_ALLOC, 24'hFFFFFF, 32'd0));
      wait_quiet();

      // region below header size and oversized region
      write_csr(CSR_HEAP_BYTES, 32'd8);
      push_req(make_req(KIND_REBUILD, 24'd0, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'd4, 32'd0));
      wait_quiet();
      write_csr(CSR_HEAP_BASE, 32'h0);
      write_csr(CSR_HEAP_BYTES, 32'h1FFFFFF);
      push_req(make_req(KIND_REBUILD, 24'd0, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'hFFFFFF, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'hFFFFEF, 32'd0));
      push_req(make_req(KIND_ALLOC, 24'hFFFFFF, 32'd0));
      wait_quiet();
      live_ptrs.delete();

      // random phases across several region settings, ending with the largest heap
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_HEAP_BASE, $urandom);
         write_csr(CSR_HEAP_BYTES, (ph == 5) ? 32'd16777216 :
                   (ph % 2) ? $urandom_range(32, 4096) : $urandom_range(2048, 65536));
         push_req(make_req(KIND_REBUILD, 24'd0, 32'd0));
         live_ptrs.delete();
         wait_quiet();
         random_burst(220, (ph % 2) ? 64 : 1024);
         wait_quiet();
      end
      wait_quiet();

      $display("covered %0d transfers sent, %0d results checked over empty, tiny,",
               n_sent, n_checked);
      $display("clamped and random heaps, with one long result stall");
      if (n_fail == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ffba_pkg.sv
hdl/ffba_table.sv
hdl/first_fit_block_allocator.sv
dv/tb_first_fit_block_allocator.sv
